/* src/alle_pkg.sv */
package alle_pkg;

  localparam int unsigned SLOTS_DEF = 16;
  localparam int unsigned VALUE_BITS_DEF = 32;

  localparam int unsigned ACTION_W = 3;
  localparam int unsigned STATUS_W = 3;
  localparam int unsigned PORT_W = 4;

  typedef enum logic [ACTION_W-1:0] {
    ACT_INS_AFTER  = 3'd0,
    ACT_INS_BEFORE = 3'd1,
    ACT_DELETE     = 3'd2,
    ACT_SLOT_OF    = 3'd3,
    ACT_LOGIC_OF   = 3'd4,
    ACT_COMPACT    = 3'd5
  } action_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 3'd0,
    ST_FULL  = 3'd1,
    ST_BAD   = 3'd2,
    ST_EMPTY = 3'd3,
    ST_RANGE = 3'd4
  } status_t;

  typedef enum logic [3:0] {
    S_INIT,
    S_IDLE,
    S_DECIDE,
    S_INS_LINK,
    S_DEL_LINK,
    S_WALK_FWD,
    S_WALK_BACK,
    S_CP_READ,
    S_CP_WRITE,
    S_FREE_BUILD,
    S_DONE
  } state_t;

endpackage

/* src/alle_store.sv */
// Slot store: link arrays, valid bits and the value memories.
module alle_store #(
  parameter int unsigned SLOTS = alle_pkg::SLOTS_DEF,
  parameter int unsigned VALUE_BITS = alle_pkg::VALUE_BITS_DEF,
  parameter int unsigned AW = $clog2(SLOTS)
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic [AW-1:0]         rd_a,
  input  logic [AW-1:0]         rd_b,
  output logic [AW-1:0]         next_a,
  output logic [AW-1:0]         prev_a,
  output logic                  used_a,
  output logic [AW-1:0]         next_b,
  output logic [AW-1:0]         prev_b,
  input  logic                  wn_en,
  input  logic [AW-1:0]         wn_addr,
  input  logic [AW-1:0]         wn_data,
  input  logic                  wn2_en,
  input  logic [AW-1:0]         wn2_addr,
  input  logic [AW-1:0]         wn2_data,
  input  logic                  wp_en,
  input  logic [AW-1:0]         wp_addr,
  input  logic [AW-1:0]         wp_data,
  input  logic                  wp2_en,
  input  logic [AW-1:0]         wp2_addr,
  input  logic [AW-1:0]         wp2_data,
  input  logic                  wu_en,
  input  logic [AW-1:0]         wu_addr,
  input  logic                  wu_data,
  input  logic                  val_we,
  input  logic [AW-1:0]         val_waddr,
  input  logic [VALUE_BITS-1:0] val_wdata,
  input  logic [AW-1:0]         val_raddr,
  output logic [VALUE_BITS-1:0] val_rdata,
  input  logic                  scr_we,
  input  logic [AW-1:0]         scr_addr,
  input  logic [VALUE_BITS-1:0] scr_wdata,
  output logic [VALUE_BITS-1:0] scr_rdata
);
  import alle_pkg::*;

  logic [AW-1:0]         next_r [SLOTS];
  logic [AW-1:0]         prev_r [SLOTS];
  logic [SLOTS-1:0]      used_r;
  logic [VALUE_BITS-1:0] val_mem [SLOTS];
  logic [VALUE_BITS-1:0] scr_mem [SLOTS];

  // Link arrays reset to the initial free chain; later writes win.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < SLOTS; i++) begin
        next_r[i] <= (i == 0 || i == SLOTS - 1) ? '0 : AW'(i + 1);
        prev_r[i] <= '0;
      end
      used_r <= '0;
    end else begin
      if (wn_en) next_r[wn_addr] <= wn_data;
      if (wn2_en) next_r[wn2_addr] <= wn2_data;
      if (wp_en) prev_r[wp_addr] <= wp_data;
      if (wp2_en) prev_r[wp2_addr] <= wp2_data;
      if (wu_en) used_r[wu_addr] <= wu_data;
    end
  end

  assign next_a = next_r[rd_a];
  assign prev_a = prev_r[rd_a];
  assign used_a = used_r[rd_a];
  assign next_b = next_r[rd_b];
  assign prev_b = prev_r[rd_b];

  // Value and scratch memories with registered reads.
  always_ff @(posedge clk) begin
    if (val_we) val_mem[val_waddr] <= val_wdata;
    val_rdata <= val_mem[val_raddr];
    if (scr_we) scr_mem[scr_addr] <= scr_wdata;
    scr_rdata <= scr_mem[scr_addr];
  end

endmodule

/* src/array_linked_list_engine_top.sv */
// Linked-list engine over a fixed slot array with a free chain. One request
// is taken at a time; in_ready is low while it runs and while its result
// waits. Successful inserts and deletes pass S_DECIDE and a link state
// before S_DONE. Rejected requests, unknown actions and a compaction of an
// already ordered list go from S_DECIDE straight to S_DONE. Index lookups
// follow one link per step. A compaction gathers values into scratch, writes
// them back in slot order and rebuilds the free chain. All of these run on
// the single link-walk sequencer and the registered read of the value and
// scratch memories. in_ready returns in the cycle after a result is accepted.
// Reset needs no clearing pass; the first request is taken once S_INIT is left.
module array_linked_list_engine_top #(
  parameter int unsigned SLOTS = alle_pkg::SLOTS_DEF,
  parameter int unsigned VALUE_BITS = alle_pkg::VALUE_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [alle_pkg::ACTION_W-1:0]     in_action,
  input  logic [alle_pkg::PORT_W-1:0]       in_position,
  input  logic [VALUE_BITS-1:0]             in_value,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [alle_pkg::STATUS_W-1:0]     out_status,
  output logic [alle_pkg::PORT_W-1:0]       out_slot,
  output logic [alle_pkg::PORT_W-1:0]       out_logical_index,
  output logic [alle_pkg::PORT_W-1:0]       out_count
);
  import alle_pkg::*;

  localparam int unsigned AW = $clog2(SLOTS);
  localparam int unsigned CW = $clog2(SLOTS + 1);

  state_t state_r, state_nxt;
  logic [ACTION_W-1:0]   act_r, act_nxt;
  logic [PORT_W-1:0]     pos_r, pos_nxt;
  logic [VALUE_BITS-1:0] val_r, val_nxt;
  logic [AW-1:0]         first_r, first_nxt, last_r, last_nxt, free_r, free_nxt;
  logic [CW-1:0]         cnt_r, cnt_nxt;
  logic                  ord_r, ord_nxt;
  logic [AW-1:0]         walk_r, walk_nxt, newslot_r, newslot_nxt;
  logic [CW-1:0]         idx_r, idx_nxt;
  logic [STATUS_W-1:0]   st_r, st_nxt;
  logic [PORT_W-1:0]     oslot_r, oslot_nxt, olog_r, olog_nxt;
  logic                  ovalid_r, ovalid_nxt;

  logic [AW-1:0] rd_a, rd_b, next_a, prev_a, next_b, prev_b;
  logic          used_a;
  logic          wn_en, wn2_en, wp_en, wp2_en, wu_en, wu_data, val_we, scr_we;
  logic [AW-1:0] wn_addr, wn_data, wn2_addr, wn2_data, wp_addr, wp_data;
  logic [AW-1:0] wp2_addr, wp2_data, wu_addr, val_waddr, val_raddr, scr_addr;
  logic [VALUE_BITS-1:0] val_wdata, val_rdata, scr_rdata;

  alle_store #(.SLOTS(SLOTS), .VALUE_BITS(VALUE_BITS), .AW(AW)) u_store (
    .clk, .rst_n, .rd_a, .rd_b, .next_a, .prev_a, .used_a, .next_b, .prev_b,
    .wn_en, .wn_addr, .wn_data, .wn2_en, .wn2_addr, .wn2_data,
    .wp_en, .wp_addr, .wp_data, .wp2_en, .wp2_addr, .wp2_data,
    .wu_en, .wu_addr, .wu_data, .val_we, .val_waddr, .val_wdata, .val_raddr,
    .val_rdata, .scr_we, .scr_addr, .scr_wdata(val_rdata), .scr_rdata
  );

  logic pos_ok;
  logic [AW-1:0] pos_a;
  assign pos_ok = ({{(32 - PORT_W){1'b0}}, pos_r} < 32'(SLOTS));
  assign pos_a = AW'(pos_r);

  assign in_ready = (state_r == S_IDLE) && !ovalid_r;
  assign out_valid = ovalid_r;
  assign out_status = st_r;
  assign out_slot = oslot_r;
  assign out_logical_index = olog_r;
  assign out_count = PORT_W'(cnt_r);

  // Control and list registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_INIT;
      first_r <= '0;
      last_r <= '0;
      free_r <= AW'(1);
      cnt_r <= '0;
      ord_r <= 1'b1;
      ovalid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      first_r <= first_nxt;
      last_r <= last_nxt;
      free_r <= free_nxt;
      cnt_r <= cnt_nxt;
      ord_r <= ord_nxt;
      ovalid_r <= ovalid_nxt;
    end
  end

  // Request and working registers.
  always_ff @(posedge clk) begin
    act_r <= act_nxt;
    pos_r <= pos_nxt;
    val_r <= val_nxt;
    walk_r <= walk_nxt;
    newslot_r <= newslot_nxt;
    idx_r <= idx_nxt;
    st_r <= st_nxt;
    oslot_r <= oslot_nxt;
    olog_r <= olog_nxt;
  end

  // Sequencer.
  always_comb begin
    state_nxt = state_r;
    act_nxt = act_r; pos_nxt = pos_r; val_nxt = val_r;
    first_nxt = first_r; last_nxt = last_r; free_nxt = free_r;
    cnt_nxt = cnt_r; ord_nxt = ord_r; walk_nxt = walk_r;
    newslot_nxt = newslot_r; idx_nxt = idx_r; st_nxt = st_r;
    oslot_nxt = oslot_r; olog_nxt = olog_r;
    ovalid_nxt = ovalid_r && !out_ready;
    rd_a = pos_a; rd_b = walk_r;
    wn_en = 1'b0; wn_addr = '0; wn_data = '0;
    wn2_en = 1'b0; wn2_addr = '0; wn2_data = '0;
    wp_en = 1'b0; wp_addr = '0; wp_data = '0;
    wp2_en = 1'b0; wp2_addr = '0; wp2_data = '0;
    wu_en = 1'b0; wu_addr = '0; wu_data = 1'b0;
    val_we = 1'b0; val_waddr = newslot_r; val_wdata = val_r;
    val_raddr = walk_r; scr_we = 1'b0; scr_addr = AW'(idx_r);
    case (state_r)
      S_INIT: state_nxt = S_IDLE;
      S_IDLE: begin
        if (in_valid && in_ready) begin
          act_nxt = in_action;
          pos_nxt = in_position;
          val_nxt = in_value;
          st_nxt = ST_OK;
          oslot_nxt = '0;
          olog_nxt = '0;
          state_nxt = S_DECIDE;
        end
      end
      S_DECIDE: begin
        rd_a = pos_a;
        rd_b = free_r;
        state_nxt = S_DONE;
        case (act_r)
          ACT_INS_AFTER, ACT_INS_BEFORE: begin
            if (!pos_ok) st_nxt = ST_BAD;
            else if (free_r == '0) st_nxt = ST_FULL;
            else if (cnt_r != '0 && !(act_r == ACT_INS_AFTER && pos_a == last_r)
                     && !(act_r == ACT_INS_BEFORE && pos_a == first_r)
                     && (pos_a == '0 || !used_a)) st_nxt = ST_BAD;
            else begin
              // Pop the free head and store the value.
              newslot_nxt = free_r;
              free_nxt = next_b;
              wu_en = 1'b1; wu_addr = free_r; wu_data = 1'b1;
              val_we = 1'b1; val_waddr = free_r;
              oslot_nxt = PORT_W'(free_r);
              cnt_nxt = cnt_r + CW'(1);
              state_nxt = S_INS_LINK;
            end
          end
          ACT_DELETE: begin
            if (cnt_r == '0) st_nxt = ST_EMPTY;
            else if (!pos_ok || pos_a == '0 || !used_a) st_nxt = ST_BAD;
            else state_nxt = S_DEL_LINK;
          end
          ACT_SLOT_OF: begin
            if ({{(CW + 1){1'b0}}, pos_r} >= (PORT_W + CW + 1)'(cnt_r)) st_nxt = ST_RANGE;
            else begin
              walk_nxt = first_r;
              idx_nxt = '0;
              state_nxt = S_WALK_FWD;
            end
          end
          ACT_LOGIC_OF: begin
            if (!pos_ok || pos_a == '0 || !used_a) st_nxt = ST_BAD;
            else begin
              walk_nxt = pos_a;
              idx_nxt = '0;
              state_nxt = S_WALK_BACK;
            end
          end
          ACT_COMPACT: begin
            if (!ord_r) begin
              walk_nxt = first_r;
              idx_nxt = CW'(1);
              state_nxt = S_CP_READ;
            end
          end
          default: ;
        endcase
      end
      S_INS_LINK: begin
        rd_a = pos_a;
        state_nxt = S_DONE;
        if (cnt_r == CW'(1)) begin
          wn_en = 1'b1; wn_addr = newslot_r; wn_data = '0;
          wp_en = 1'b1; wp_addr = newslot_r; wp_data = '0;
          first_nxt = newslot_r; last_nxt = newslot_r;
          ord_nxt = (newslot_r == AW'(1));
        end else if (act_r == ACT_INS_AFTER && pos_a == last_r) begin
          wn_en = 1'b1; wn_addr = newslot_r; wn_data = '0;
          wp_en = 1'b1; wp_addr = newslot_r; wp_data = last_r;
          wn2_en = 1'b1; wn2_addr = last_r; wn2_data = newslot_r;
          ord_nxt = ord_r && (CW'(newslot_r) == cnt_r);
          last_nxt = newslot_r;
        end else if (act_r == ACT_INS_BEFORE && pos_a == first_r) begin
          wp_en = 1'b1; wp_addr = newslot_r; wp_data = '0;
          wn_en = 1'b1; wn_addr = newslot_r; wn_data = first_r;
          wp2_en = 1'b1; wp2_addr = first_r; wp2_data = newslot_r;
          first_nxt = newslot_r;
          ord_nxt = 1'b0;
        end else if (act_r == ACT_INS_AFTER) begin
          wn_en = 1'b1; wn_addr = newslot_r; wn_data = next_a;
          wp_en = 1'b1; wp_addr = newslot_r; wp_data = pos_a;
          wp2_en = 1'b1; wp2_addr = next_a; wp2_data = newslot_r;
          wn2_en = 1'b1; wn2_addr = pos_a; wn2_data = newslot_r;
          ord_nxt = 1'b0;
        end else begin
          wp_en = 1'b1; wp_addr = newslot_r; wp_data = prev_a;
          wn_en = 1'b1; wn_addr = newslot_r; wn_data = pos_a;
          wn2_en = 1'b1; wn2_addr = prev_a; wn2_data = newslot_r;
          wp2_en = 1'b1; wp2_addr = pos_a; wp2_data = newslot_r;
          ord_nxt = 1'b0;
        end
      end
      S_DEL_LINK: begin
        rd_a = pos_a;
        state_nxt = S_DONE;
        cnt_nxt = cnt_r - CW'(1);
        wu_en = 1'b1; wu_addr = pos_a; wu_data = 1'b0;
        free_nxt = pos_a;
        if (pos_a == last_r) begin
          last_nxt = prev_a;
          if (prev_a != '0) begin
            wn2_en = 1'b1; wn2_addr = prev_a; wn2_data = '0;
          end
          if (cnt_r == CW'(1)) begin
            first_nxt = '0; last_nxt = '0; ord_nxt = 1'b1;
          end
        end else if (pos_a == first_r) begin
          first_nxt = next_a;
          wp2_en = 1'b1; wp2_addr = next_a; wp2_data = '0;
          ord_nxt = 1'b0;
        end else begin
          wn2_en = 1'b1; wn2_addr = prev_a; wn2_data = next_a;
          wp2_en = 1'b1; wp2_addr = next_a; wp2_data = prev_a;
          ord_nxt = 1'b0;
        end
        // The freed slot's own links; the neighbor updates never address it.
        wn_en = 1'b1; wn_addr = pos_a; wn_data = free_r;
        wp_en = 1'b1; wp_addr = pos_a; wp_data = '0;
      end
      S_WALK_FWD: begin
        rd_b = walk_r;
        if (idx_r == CW'(pos_r)) begin
          oslot_nxt = PORT_W'(walk_r);
          state_nxt = S_DONE;
        end else begin
          walk_nxt = next_b;
          idx_nxt = idx_r + CW'(1);
        end
      end
      S_WALK_BACK: begin
        rd_b = walk_r;
        if (prev_b == '0 || idx_r == CW'(SLOTS)) begin
          olog_nxt = PORT_W'(idx_r);
          state_nxt = S_DONE;
        end else begin
          walk_nxt = prev_b;
          idx_nxt = idx_r + CW'(1);
        end
      end
      S_CP_READ: begin
        // Gather values in list order into scratch, one per S_CP_READ/S_CP_WRITE pass.
        rd_b = walk_r;
        val_raddr = walk_r;
        if (idx_r > cnt_r || idx_r == CW'(SLOTS)) begin
          idx_nxt = CW'(1);
          state_nxt = S_CP_WRITE;
        end else begin
          walk_nxt = next_b;
          state_nxt = S_CP_WRITE;
          newslot_nxt = '1;
        end
      end
      S_CP_WRITE: begin
        if (newslot_r == '1 && act_r == ACT_COMPACT) begin
          // Scratch write of the value read last cycle.
          scr_we = 1'b1;
          newslot_nxt = '0;
          idx_nxt = idx_r + CW'(1);
          state_nxt = S_CP_READ;
        end else begin
          // Write back from scratch and relink slot idx.
          scr_addr = AW'(idx_r);
          if (idx_r > cnt_r || idx_r == CW'(SLOTS)) begin
            idx_nxt = cnt_r + CW'(1);
            state_nxt = S_FREE_BUILD;
          end else if (newslot_r == '0) begin
            newslot_nxt = AW'(1);
          end else begin
            val_we = 1'b1; val_waddr = AW'(idx_r); val_wdata = scr_rdata;
            wu_en = 1'b1; wu_addr = AW'(idx_r); wu_data = 1'b1;
            wp_en = 1'b1; wp_addr = AW'(idx_r); wp_data = AW'(idx_r - CW'(1));
            wn_en = 1'b1; wn_addr = AW'(idx_r);
            wn_data = (idx_r < cnt_r) ? AW'(idx_r + CW'(1)) : '0;
            idx_nxt = idx_r + CW'(1);
            newslot_nxt = '0;
          end
        end
      end
      S_FREE_BUILD: begin
        if (idx_r >= CW'(SLOTS)) begin
          free_nxt = (cnt_r + CW'(1) < CW'(SLOTS)) ? AW'(cnt_r + CW'(1)) : '0;
          first_nxt = (cnt_r != '0) ? AW'(1) : '0;
          last_nxt = AW'(cnt_r);
          ord_nxt = 1'b1;
          state_nxt = S_DONE;
        end else begin
          wu_en = 1'b1; wu_addr = AW'(idx_r); wu_data = 1'b0;
          wp_en = 1'b1; wp_addr = AW'(idx_r); wp_data = '0;
          wn_en = 1'b1; wn_addr = AW'(idx_r);
          wn_data = (idx_r + CW'(1) < CW'(SLOTS)) ? AW'(idx_r + CW'(1)) : '0;
          idx_nxt = idx_r + CW'(1);
        end
      end
      S_DONE: begin
        ovalid_nxt = 1'b1;
        state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // No new transaction is taken while a result is pending or work runs.
  assert property (@(posedge clk) disable iff (!rst_n)
    in_ready |-> !out_valid && state_r == S_IDLE)
    else $error("ready while busy");
  assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CW'(SLOTS - 1))
    else $error("count overflow");
  assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r == '0 && state_r == S_IDLE) |-> first_r == '0 && last_r == '0)
    else $error("empty list with ends");
  assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> state_r == S_DECIDE)
    else $error("accepted transaction not started");

endmodule
